// ----- design/sfq_pkg.sv -----
// sfq_pkg: shared widths, command and status codes and sequencer state type
// for the searchable fifo queue; no dependencies
package sfq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_POPRD = 7'b0000100,
      S_RD    = 7'b0001000,
      S_CMP   = 7'b0010000,
      S_SHRD  = 7'b0100000,
      S_SHWR  = 7'b1000000
   } state_type;

endpackage

// ----- design/sfq_mem.sv -----
// sfq_mem: entry storage, one write port and one read port with registered data
// depends on sfq_pkg for the data width
module sfq_mem #(
   parameter int DEPTH = sfq_pkg::DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic [sfq_pkg::DATA_W-1:0]             wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic [sfq_pkg::DATA_W-1:0]             rd_data
);
   import sfq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/searchable_fifo_queue.sv -----
// searchable_fifo_queue: top level, sequencer around a circular entry store
// depends on sfq_pkg and sfq_mem
//
// usage
//   a command is taken on a clock edge with start high and busy low; req_cmd
//   selects push, pop, search or remove-newest-match, req_value carries the data
//   exactly one result follows per command: rsp_valid is high for one cycle with
//   rsp_popped_value, rsp_hit, rsp_status and rsp_occupancy; the receiver cannot
//   stall, so the result is taken on the edge that ends that cycle
//   busy stays high from the cycle after the transfer until the result is shown;
//   the next command may be given in the same cycle as the result
// sequencing, set by the single memory read port and the one shared comparator
//   push: the tail slot is written in S_EXEC, which also raises the result
//   pop: S_EXEC reads the head slot, S_POPRD takes the registered memory data
//   search / remove: S_RD then S_CMP for each entry inspected, newest first
//   remove then compacts the newer entries, S_SHRD then S_SHWR per entry moved down
//   the worst case is a remove of the oldest entry of a full queue
// reset
//   synchronous, active high; the queue comes out empty, no clearing pass, the
//   stored words are only read below the fill count
// a push to a full queue is dropped with status full; a pop of an empty queue
// returns zero with status empty
module searchable_fifo_queue #(
   parameter int DEPTH = sfq_pkg::DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic        [sfq_pkg::CMD_W-1:0]     req_cmd,
   input  logic signed [sfq_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic signed [sfq_pkg::DATA_W-1:0]    rsp_popped_value,
   output logic                                 rsp_hit,
   output logic        [sfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic        [sfq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import sfq_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [AW:0]      DEPTH_EXT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0]    LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   // circular index helpers
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
      return (a == LAST_IDX) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
      return (a == '0) ? LAST_IDX : a - 1'b1;
   endfunction

   // occupancy field is the low bits of the fill count
   function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
      logic [CNT_W+OCC_W-1:0] e;
      e = {{OCC_W{1'b0}}, c};
      return e[OCC_W-1:0];
   endfunction

   // control state
   state_type         state_ff,  state_in;
   logic [AW-1:0]     head_ff,   head_in;     // slot of the oldest entry
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;      // fill count
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers of the current command
   cmd_type           cmd_ff,    cmd_in;
   logic [DATA_W-1:0] key_ff,    key_in;
   logic [AW-1:0]     addr_ff,   addr_in;     // slot under inspection / being moved
   logic [CNT_W-1:0]  left_ff,   left_in;     // entries not yet compared
   logic [CNT_W-1:0]  newer_ff,  newer_in;    // entries newer than addr_ff

   // result registers
   logic [DATA_W-1:0] popped_ff, popped_in;
   logic              hit_ff,    hit_in;
   status_type        status_ff, status_in;
   logic [OCC_W-1:0]  occ_ff,    occ_in;

   // memory port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              match;

   sfq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the shared comparator: registered read data against the search key
   assign match = (rd_data == key_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      newer_in     = newer_ff;
      rsp_valid_in = 1'b0;
      popped_in    = '0;
      hit_in       = 1'b0;
      status_in    = ST_OK;
      occ_in       = occ_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = key_ff;
      rd_addr      = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_cmd);
               key_in   = req_value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_ff)
               CMD_PUSH: begin
                  // append at the tail slot
                  if (cnt_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = wrap_add(head_ff, cnt_ff[AW-1:0]);
                     cnt_in  = cnt_ff + ONE_CNT;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               CMD_POP: begin
                  rd_addr = head_ff;
                  if (cnt_ff == '0) begin
                     status_in    = ST_EMPTY;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_POPRD;
                  end
               end
               CMD_SEARCH, CMD_REMOVE: begin
                  // scan from the newest entry towards the oldest
                  if (cnt_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     addr_in  = wrap_add(head_ff, AW'(cnt_ff - ONE_CNT));
                     left_in  = cnt_ff;
                     newer_in = '0;
                     state_in = S_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_POPRD: begin
            popped_in    = rd_data;
            head_in      = idx_inc(head_ff);
            cnt_in       = cnt_ff - ONE_CNT;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_RD: begin
            rd_addr  = addr_ff;
            state_in = S_CMP;
         end

         S_CMP: begin
            if (match) begin
               hit_in = 1'b1;
               if (cmd_ff == CMD_REMOVE && newer_ff != '0) begin
                  // close the gap: move each newer entry down one slot
                  state_in = S_SHRD;
               end else begin
                  if (cmd_ff == CMD_REMOVE) begin
                     cnt_in = cnt_ff - ONE_CNT;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (left_ff == ONE_CNT) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               addr_in  = idx_dec(addr_ff);
               left_in  = left_ff - ONE_CNT;
               newer_in = newer_ff + ONE_CNT;
               state_in = S_RD;
            end
         end

         S_SHRD: begin
            rd_addr  = idx_inc(addr_ff);
            state_in = S_SHWR;
         end

         S_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = addr_ff;
            wr_data  = rd_data;
            addr_in  = idx_inc(addr_ff);
            newer_in = newer_ff - ONE_CNT;
            if (newer_ff == ONE_CNT) begin
               cnt_in       = cnt_ff - ONE_CNT;
               hit_in       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SHRD;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (rsp_valid_in) begin
         occ_in = occ_of(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      addr_ff   <= addr_in;
      left_ff   <= left_in;
      newer_ff  <= newer_in;
      popped_ff <= popped_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      occ_ff    <= occ_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = $signed(popped_ff);
   assign rsp_hit          = hit_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// ----- design/sfq_checker.sv -----
// sfq_checker: port-level assertions for the searchable fifo queue, bound to the top
// depends on sfq_pkg and searchable_fifo_queue
module sfq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [sfq_pkg::DATA_W-1:0]    rsp_popped_value,
   input logic                                 rsp_hit,
   input logic        [sfq_pkg::STATUS_W-1:0]  rsp_status,
   input logic        [sfq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import sfq_pkg::*;

   // a transfer always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("no work after transfer");

   // a result is only shown once the command is finished
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // empty pop leaves nothing and returns zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_occupancy == '0 && rsp_popped_value == '0 && !rsp_hit))
      else $error("bad empty result");

   // a hit comes only from search or remove
   a_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_status == ST_OK && rsp_popped_value == '0))
      else $error("bad hit result");

   // one result per command: a result is followed by no second result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind searchable_fifo_queue sfq_checker u_sfq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_popped_value (rsp_popped_value),
   .rsp_hit          (rsp_hit),
   .rsp_status       (rsp_status),
   .rsp_occupancy    (rsp_occupancy)
);

// ----- verif/searchable_fifo_queue_tb.sv -----
// searchable_fifo_queue_tb: self-checking bench for the searchable fifo queue
// drives push, pop, search and remove commands and checks every result
// against an in-bench queue predictor; depends on sfq_pkg and the design
module searchable_fifo_queue_tb;
   import sfq_pkg::*;

   localparam int DEPTH           = DEPTH_DEF;
   // worst command is a remove of the oldest entry of a full queue
   localparam int SETTLE_CYCLES   = 4 * DEPTH + 8;
   // cycles with neither a command transfer nor a result before giving up
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int RANDOM_ITEMS    = 1820;

   // one result as the predictor sees it
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic                     hit;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
   } queue_reply;

   // command mixes for the random traffic
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [CMD_W-1:0]           req_cmd = CMD_PUSH;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_popped_value;
   logic                       rsp_hit;
   logic [STATUS_W-1:0]        rsp_status;
   logic [OCC_W-1:0]           rsp_occupancy;

   // predictor state: oldest entry at index 0, newest at the back
   logic signed [DATA_W-1:0]   held_entries[$];
   // results still owed by the design, oldest first
   queue_reply                 pending_replies[$];
   int                         fail_count = 0;
   int                         idle_cycles = 0;
   bit                         sender_idles = 1'b1;

   searchable_fifo_queue #(
      .DEPTH (DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one command to the predictor state and return the result it owes
   function automatic queue_reply apply_command(input cmd_type c,
                                                input logic signed [DATA_W-1:0] v);
      queue_reply r;
      int         k;
      r = '0;
      r.status = ST_OK;
      case (c)
         CMD_PUSH: begin
            // a full queue drops the value and keeps its state
            if (held_entries.size() < DEPTH)
               held_entries.push_back(v);
            else
               r.status = ST_FULL;
         end
         CMD_POP: begin
            if (held_entries.size() == 0)
               r.status = ST_EMPTY;
            else
               r.popped_value = held_entries.pop_front();
         end
         CMD_SEARCH: begin
            foreach (held_entries[i])
               if (held_entries[i] == v)
                  r.hit = 1'b1;
         end
         CMD_REMOVE: begin
            // newest match only, older duplicates stay in place
            for (k = held_entries.size() - 1; k >= 0 && !r.hit; k--) begin
               if (held_entries[k] == v) begin
                  held_entries.delete(k);
                  r.hit = 1'b1;
               end
            end
         end
      endcase
      r.occupancy = OCC_W'(held_entries.size());
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // one command transfer; the sender may idle first, then holds start until taken
   task automatic send_command(input cmd_type c, input logic signed [DATA_W-1:0] v);
      int gap;
      gap = 0;
      if (sender_idles)
         while ($urandom_range(99) < 34 && gap < 12)
            gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= c;
      req_value <= v;
      // busy is sampled before the design updates it at this edge
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_replies.push_back(apply_command(c, v));
   endtask

   // sender stays quiet until every owed result has come back
   task automatic await_replies();
      start <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   function automatic cmd_type pick_command(input traffic_mix mix);
      int r;
      int push_lim;
      int pop_lim;
      int search_lim;
      r = $urandom_range(99);
      case (mix)
         MIX_FILL:  begin push_lim = 60; pop_lim = 70; search_lim = 85; end
         MIX_DRAIN: begin push_lim = 15; pop_lim = 60; search_lim = 75; end
         default:   begin push_lim = 25; pop_lim = 50; search_lim = 75; end
      endcase
      if (r < push_lim)
         return CMD_PUSH;
      else if (r < pop_lim)
         return CMD_POP;
      else if (r < search_lim)
         return CMD_SEARCH;
      else
         return CMD_REMOVE;
   endfunction

   // small value pool so that duplicates and hits are common, plus full-range noise
   function automatic logic signed [DATA_W-1:0] pick_value(input cmd_type c);
      logic signed [DATA_W-1:0] pool[8];
      int                       r;
      pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1,
               32'sh1, 32'sh5a5a_5a5a, 32'sha5a5_a5a5, 32'sh2a};
      r = $urandom_range(9);
      // search and remove often aim at a held entry anywhere in the age order
      if ((c == CMD_SEARCH || c == CMD_REMOVE) && held_entries.size() != 0 && r < 4)
         return held_entries[$urandom_range(held_entries.size() - 1)];
      else if (r < 7)
         return pool[$urandom_range(7)];
      else
         return $urandom;
   endfunction

   // empty-queue cases, extreme values, duplicates and misses
   task automatic test_directed_basics();
      send_command(CMD_POP,    32'sh0);
      send_command(CMD_SEARCH, 32'sh0);
      send_command(CMD_REMOVE, 32'sh0);
      send_command(CMD_PUSH,   32'sh8000_0000);
      send_command(CMD_PUSH,   32'sh7fff_ffff);
      send_command(CMD_PUSH,   32'sh0);
      send_command(CMD_PUSH,   -32'sh1);
      send_command(CMD_PUSH,   32'sh7fff_ffff);
      send_command(CMD_SEARCH, 32'sh7fff_ffff);
      send_command(CMD_SEARCH, 32'sh5);
      // two equal entries, only the newer may go
      send_command(CMD_REMOVE, 32'sh7fff_ffff);
      send_command(CMD_REMOVE, 32'sh7b);
      send_command(CMD_POP,    32'sh0);
      send_command(CMD_POP,    32'sh0);
      await_replies();
   endtask

   // fill to the brim, overflow, then the longest remove and search
   task automatic test_full_queue();
      int k;
      for (k = held_entries.size(); k < DEPTH; k++)
         send_command(CMD_PUSH, 32'sh1000 + k);
      send_command(CMD_PUSH, 32'sh7777_7777);
      // oldest entry is 0 from the basics test, so every newer word moves down
      send_command(CMD_REMOVE, held_entries[0]);
      send_command(CMD_SEARCH, held_entries[0]);
      await_replies();
   endtask

   // random runs of commands biased towards filling, draining or an even mix
   task automatic test_random_traffic(input int n_items);
      int         sent;
      int         run_len;
      traffic_mix mix;
      cmd_type    c;
      sent = 0;
      while (sent < n_items) begin
         mix     = traffic_mix'($urandom_range(2));
         run_len = $urandom_range(20, 120);
         if (run_len > n_items - sent)
            run_len = n_items - sent;
         // one long stretch somewhere in the middle with the sender never idling
         sender_idles = !(sent >= n_items / 3 && sent < n_items / 3 + 300);
         repeat (run_len) begin
            c = pick_command(mix);
            send_command(c, pick_value(c));
            sent++;
         end
         if ($urandom_range(3) == 0)
            await_replies();
      end
      sender_idles = 1'b1;
   endtask

   // result checker: the receiver cannot stall, so every strobe is a transfer
   always @(posedge clock) begin
      queue_reply want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual %0h",
                     $time, {rsp_popped_value, rsp_hit, rsp_status, rsp_occupancy});
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("popped_value", want.popped_value, rsp_popped_value);
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         end
      end
   end

   // watchdog on cycles without any command transfer or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("searchable_fifo_queue_tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_full_queue();
      test_random_traffic(RANDOM_ITEMS);
      await_replies();
      // let any stray result show itself before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("searchable_fifo_queue_tb OK");
      else
         $display("searchable_fifo_queue_tb NOT OK");
      $finish;
   end

endmodule
